// File: rtl/core/clc_pkg.sv
// clc_pkg: shared types and constants for the CSV label classifier.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package clc_pkg;

   // record class codes as carried on the result tuser
   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_DOS   = 2'd1,
      CLASS_BDOOR = 2'd2,
      CLASS_RECON = 2'd3
   } class_type;

   localparam int unsigned HISTORY_DEPTH = 13;
   localparam int unsigned WINDOW_BITS   = 8 * (HISTORY_DEPTH + 1);
   localparam int unsigned SUM_BITS      = 64;
   localparam int unsigned FIELD_BITS    = 9;   // saturates at 256
   localparam int unsigned OUT_CNT_BITS  = 32;

   localparam logic [7:0]   COMMA_CHAR    = 8'h2C;
   localparam logic [7:0]   LABEL_COL_RST = 8'd47;
   localparam logic [23:0]  PAT_DOS       = "DoS";
   localparam logic [63:0]  PAT_BDOOR     = "Backdoor";
   localparam logic [111:0] PAT_RECON     = "Reconnaissance";

   // front-to-back queue
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_BITS   = 1;

   // one finished record, handed from the parser to the counter stage
   typedef struct packed {
      class_type            cls;
      logic [SUM_BITS-1:0]  sum;
   } event_type;

endpackage

`default_nettype wire

// File: rtl/core/csv_label_classifier.sv
// csv_label_classifier: top level. Parser front, event queue, counter back.
// Depends on clc_pkg, clc_front, clc_queue and clc_back.
//
// Usage:
//   req_*  : one record byte per beat, tdata = data_byte, tlast marks the
//            last byte of a record.
//   rsp_*  : one beat per record, sent for the tlast byte. tuser carries
//            the class (0 none, 1 DoS, 2 Backdoor, 3 Reconnaissance).
//   csr_*  : write of label_column, the non-empty field index scanned for
//            labels. Always ready; write only while the block is idle.
// Throughput: one byte per cycle while the queue is not full, including
//   back-to-back record ends; the parser's window compares are combinational.
// Path: the tlast beat writes the queue, then the counter stage pops the
//   event and loads the output register that drives rsp_tvalid; a stalled
//   rsp delays the pop.
// Stall: a stalled rsp holds its beat; the two-entry queue fills and then
//   req_tready drops until the back drains it.
// Reset: synchronous; label_column returns to 47, counts and sum to zero,
//   no result pending.
`default_nettype none

module csv_label_classifier #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [7:0]     csr_data,    // label_column
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [7:0]     req_tdata,   // data_byte
   input  wire logic           req_tlast,   // end_of_record
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   // dos_total[31:0], backdoor_total[63:32], recon_total[95:64],
   // suspicious_total[127:96], byte_sum[191:128]
   output logic [191:0]        rsp_tdata,
   output logic [1:0]          rsp_tuser    // record_class
);
   import clc_pkg::*;

   event_type push_data, pop_data;
   logic      push, full, pop, not_empty;
   logic      req_beat;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;
   assign req_beat   = req_tvalid && req_tready;

   clc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .byte_valid (req_beat),
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .evt_data   (push_data),
      .evt_push   (push)
   );

   clc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   clc_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .evt_valid  (not_empty),
      .evt_data   (pop_data),
      .evt_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: rtl/core/clc_front.sv
// clc_front: byte parser. Tracks non-empty fields, scans the label field for
// the three keywords and emits one event per record. Depends on clc_pkg.
`default_nettype none

module clc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [7:0]          csr_data,
   input  wire logic                byte_valid,
   input  wire logic [7:0]          byte_data,
   input  wire logic                byte_last,
   output clc_pkg::event_type       evt_data,
   output logic                     evt_push
);
   import clc_pkg::*;

   logic [7:0]            label_col_ff, label_col_in;
   logic [FIELD_BITS-1:0] fields_ff, fields_in;
   logic                  inside_ff, inside_in;
   logic                  in_label_ff, in_label_in;
   logic [7:0]            hist_ff [HISTORY_DEPTH];
   logic [7:0]            hist_in [HISTORY_DEPTH];
   logic [2:0]            found_ff, found_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;

   logic [WINDOW_BITS-1:0] window;
   logic                   is_comma;
   logic                   label_now;
   logic [2:0]             found_next;
   class_type              cls;

   // window: current byte in the low bits, older bytes above it
   always_comb begin
      window[7:0] = byte_data;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         window[8*(i+1) +: 8] = hist_ff[i];
      end
   end

   assign is_comma  = (byte_data == COMMA_CHAR);
   assign label_now = inside_ff ? in_label_ff
                                : (fields_ff == {1'b0, label_col_ff});

   always_comb begin
      found_next = found_ff;
      if (!is_comma && label_now) begin
         if (window[23:0] == PAT_DOS)            found_next[0] = 1'b1;
         if (window[63:0] == PAT_BDOOR)          found_next[1] = 1'b1;
         if (window[111:0] == PAT_RECON)         found_next[2] = 1'b1;
      end
   end

   always_comb begin
      if (found_next[0])      cls = CLASS_DOS;
      else if (found_next[1]) cls = CLASS_BDOOR;
      else if (found_next[2]) cls = CLASS_RECON;
      else                    cls = CLASS_NONE;
   end

   always_comb begin
      label_col_in = csr_valid ? csr_data : label_col_ff;
      fields_in    = fields_ff;
      inside_in    = inside_ff;
      in_label_in  = in_label_ff;
      found_in     = found_ff;
      sum_in       = sum_ff;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (byte_valid) begin
         sum_in = sum_ff + {{(SUM_BITS-8){byte_data[7]}}, byte_data};
         if (is_comma) begin
            inside_in   = 1'b0;
            in_label_in = 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               hist_in[i] = 8'd0;
            end
         end else begin
            if (!inside_ff) begin
               inside_in   = 1'b1;
               in_label_in = label_now;
               if (!fields_ff[FIELD_BITS-1]) begin
                  fields_in = fields_ff + 1'b1;
               end
            end
            found_in   = found_next;
            hist_in[0] = byte_data;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
               hist_in[i] = hist_ff[i-1];
            end
         end
         if (byte_last) begin
            fields_in   = '0;
            inside_in   = 1'b0;
            in_label_in = 1'b0;
            found_in    = '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               hist_in[i] = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_col_ff <= LABEL_COL_RST;
         fields_ff    <= '0;
         inside_ff    <= 1'b0;
         in_label_ff  <= 1'b0;
         found_ff     <= '0;
         sum_ff       <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= 8'd0;
         end
      end else begin
         label_col_ff <= label_col_in;
         fields_ff    <= fields_in;
         inside_ff    <= inside_in;
         in_label_ff  <= in_label_in;
         found_ff     <= found_in;
         sum_ff       <= sum_in;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   assign evt_push     = byte_valid && byte_last;
   assign evt_data.cls = cls;
   assign evt_data.sum = sum_in;

endmodule

`default_nettype wire

// File: rtl/core/clc_queue.sv
// clc_queue: two-entry event queue between parser and counter stage.
// Depends on clc_pkg for the entry type and depth.
`default_nettype none

module clc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  clc_pkg::event_type       push_data,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output clc_pkg::event_type       pop_data
);
   import clc_pkg::*;

   event_type              mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/clc_back.sv
// clc_back: per-class saturating counters and the result register.
// Depends on clc_pkg.
`default_nettype none

module clc_back #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                evt_valid,
   input  clc_pkg::event_type       evt_data,
   output logic                     evt_pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [191:0]             rsp_tdata,
   output logic [1:0]               rsp_tuser
);
   import clc_pkg::*;

   logic [COUNT_BITS-1:0] dos_ff, dos_in;
   logic [COUNT_BITS-1:0] bd_ff, bd_in;
   logic [COUNT_BITS-1:0] rc_ff, rc_in;
   logic [COUNT_BITS-1:0] susp_ff, susp_in;
   logic                  valid_ff, valid_in;
   logic [191:0]          data_ff, data_in;
   logic [1:0]            user_ff, user_in;
   logic                  inc_dos, inc_bd, inc_rc;

   assign evt_pop = evt_valid && (!valid_ff || rsp_tready);

   assign inc_dos = (evt_data.cls == CLASS_DOS)   && (dos_ff != '1);
   assign inc_bd  = (evt_data.cls == CLASS_BDOOR) && (bd_ff  != '1);
   assign inc_rc  = (evt_data.cls == CLASS_RECON) && (rc_ff  != '1);

   // the total is min(max, sum of counts); it moves only when a class count does
   always_comb begin
      dos_in   = dos_ff;
      bd_in    = bd_ff;
      rc_in    = rc_ff;
      susp_in  = susp_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (evt_pop) begin
         if (inc_dos) dos_in = dos_ff + 1'b1;
         if (inc_bd)  bd_in  = bd_ff + 1'b1;
         if (inc_rc)  rc_in  = rc_ff + 1'b1;
         if ((inc_dos || inc_bd || inc_rc) && (susp_ff != '1)) begin
            susp_in = susp_ff + 1'b1;
         end
         valid_in = 1'b1;
         user_in  = evt_data.cls;
         data_in  = {evt_data.sum,
                     OUT_CNT_BITS'(64'(susp_in)),
                     OUT_CNT_BITS'(64'(rc_in)),
                     OUT_CNT_BITS'(64'(bd_in)),
                     OUT_CNT_BITS'(64'(dos_in))};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dos_ff   <= '0;
         bd_ff    <= '0;
         rc_ff    <= '0;
         susp_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         dos_ff   <= dos_in;
         bd_ff    <= bd_in;
         rc_ff    <= rc_in;
         susp_ff  <= susp_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

`default_nettype wire
